@@ sv/scsde_pkg.sv @@
// ---------------------------------------------------------------------------
// scsde_pkg
// Shared types and constants for the shadow call stack diff emitter.
// ---------------------------------------------------------------------------
package scsde_pkg;

    localparam int DEPTH_W = 6;
    localparam int ADDR_BITS = 64;
    localparam int KIND_W = 8;

    typedef enum logic [1:0] {
        REQ_PUSH        = 2'd0,
        REQ_POP         = 2'd1,
        REQ_EVENT_STACK = 2'd2,
        REQ_EVENT_BARE  = 2'd3
    } req_type_t;

    typedef enum logic {
        ITEM_HEADER = 1'b0,
        ITEM_FRAME  = 1'b1
    } item_kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

endpackage

@@ sv/scsde_ram.sv @@
// ---------------------------------------------------------------------------
// scsde_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module scsde_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/shadow_call_stack_diff_emitter.sv @@
// ---------------------------------------------------------------------------
// shadow_call_stack_diff_emitter
// Shadow call stack with a reported-depth mark; events emit a header, and
// events with stack also emit the frames pushed since the last report.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request item: push, pop,
//   event with stack or event without stack. Output channel
//   (out_valid/out_ready) delivers header and frame items; last marks the
//   final item of an event.
//   Push and pop emit nothing. An event emits its header plus one frame
//   item per newly reported frame; the frame walk reads the frame RAM
//   one entry per cycle while the receiver does not stall.
//   The first result appears in the output register the cycle after the
//   event is accepted. Outside a frame walk, the input is taken while a
//   result waits in the output register unless the request itself must emit.
//   Reset empties the stack, clears the mark and the failed flag; frame
//   RAM contents are not cleared (only pushed entries are ever read).
//   A receiver stall holds the output register and pauses the frame walk.
//   After a push onto a full stack all requests are taken and dropped.
// ---------------------------------------------------------------------------
module shadow_call_stack_diff_emitter
    import scsde_pkg::*;
#(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic [ADDR_BITS-1:0] caller_address,
    input  logic [KIND_W-1:0]    event_kind,
    input  logic [ADDR_BITS-1:0] event_pointer,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 item_kind,
    output logic [KIND_W-1:0]    kind_out,
    output logic [ADDR_BITS-1:0] pointer_out,
    output logic [DEPTH_W-1:0]   depth_out,
    output logic [DEPTH_W-1:0]   popped_to,
    output logic [ADDR_BITS-1:0] frame_address,
    output logic                 last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

    state_t              state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [DEPTH_W-1:0]  mark_reg, mark_next;
    logic [DEPTH_W-1:0]  idx_reg, idx_next;
    logic                failed_reg, failed_next;
    logic                out_valid_reg, out_valid_next;

    logic                 item_kind_reg;
    logic [KIND_W-1:0]    kind_out_reg;
    logic [ADDR_BITS-1:0] pointer_out_reg;
    logic [DEPTH_W-1:0]   depth_out_reg;
    logic [DEPTH_W-1:0]   popped_to_reg;
    logic [ADDR_BITS-1:0] frame_address_reg;
    logic                 last_reg;

    req_type_t            req;
    logic                 out_free;
    logic                 accept;
    logic                 has_new;
    logic [DEPTH_W-1:0]   idx_inc;
    logic [DEPTH_W-1:0]   depth_dec;
    logic                 hdr_load;
    logic                 hdr_stack;
    logic                 frame_load;
    logic                 frame_last;
    logic                 wr_en;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [ADDR_BITS-1:0] rd_data;

    assign req        = req_type_t'(req_type);
    assign out_free   = !out_valid_reg || out_ready;
    assign has_new    = mark_reg < depth_reg;
    assign idx_inc    = idx_reg + DEPTH_W'(1);
    assign depth_dec  = depth_reg - DEPTH_W'(1);
    assign frame_last = idx_inc == depth_reg;
    assign accept     = in_valid && in_ready;

    scsde_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (depth_reg[AW-1:0]),
        .wr_data (caller_address),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !failed_reg && req == REQ_EVENT_STACK && has_new)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (out_free && frame_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = 1'b0;
        hdr_load   = 1'b0;
        hdr_stack  = 1'b0;
        frame_load = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = mark_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = failed_reg || out_free ||
                           req == REQ_PUSH || req == REQ_POP;
                if (accept && !failed_reg)
                begin
                    case (req)
                        REQ_PUSH:
                        begin
                            wr_en = depth_reg < FULL_DEPTH;
                        end
                        REQ_POP:
                        begin
                        end
                        REQ_EVENT_STACK:
                        begin
                            hdr_load  = 1'b1;
                            hdr_stack = 1'b1;
                            rd_en     = has_new;
                        end
                        REQ_EVENT_BARE:
                        begin
                            hdr_load = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                rd_addr = idx_inc[AW-1:0];
                if (out_free)
                begin
                    frame_load = 1'b1;
                    rd_en      = !frame_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    // stack state
    always_comb
    begin
        depth_next  = depth_reg;
        mark_next   = mark_reg;
        failed_next = failed_reg;
        idx_next    = idx_reg;
        if (accept && !failed_reg)
        begin
            case (req)
                REQ_PUSH:
                begin
                    if (depth_reg < FULL_DEPTH)
                    begin
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                REQ_POP:
                begin
                    if (depth_reg != '0)
                    begin
                        depth_next = depth_dec;
                        if (mark_reg > depth_dec)
                        begin
                            mark_next = depth_dec;
                        end
                    end
                end
                REQ_EVENT_STACK:
                begin
                    mark_next = depth_reg;
                    idx_next  = mark_reg;
                end
                REQ_EVENT_BARE:
                begin
                end
                default:
                begin
                end
            endcase
        end
        if (frame_load)
        begin
            idx_next = idx_inc;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (hdr_load || frame_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            mark_reg      <= '0;
            idx_reg       <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            mark_reg      <= mark_next;
            idx_reg       <= idx_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (hdr_load)
        begin
            item_kind_reg     <= ITEM_HEADER;
            kind_out_reg      <= event_kind;
            pointer_out_reg   <= event_pointer;
            depth_out_reg     <= hdr_stack ? depth_reg : '0;
            popped_to_reg     <= hdr_stack ? mark_reg : '0;
            frame_address_reg <= '0;
            last_reg          <= hdr_stack ? !has_new : 1'b1;
        end
        else if (frame_load)
        begin
            item_kind_reg     <= ITEM_FRAME;
            kind_out_reg      <= '0;
            pointer_out_reg   <= '0;
            depth_out_reg     <= '0;
            popped_to_reg     <= '0;
            frame_address_reg <= rd_data;
            last_reg          <= frame_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_kind     = item_kind_reg;
    assign kind_out      = kind_out_reg;
    assign pointer_out   = pointer_out_reg;
    assign depth_out     = depth_out_reg;
    assign popped_to     = popped_to_reg;
    assign frame_address = frame_address_reg;
    assign last          = last_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shadow call stack diff emitter. A scoreboard
// tracks the shadow stack, the reported mark and the failed flag, and
// builds the header and frame items each accepted request should produce.
// Directed requests cover the corner cases, then random push/pop/event
// traffic runs with bursty input, a stalling receiver and two long holds.
// The run ends by filling the stack, walking all frames and overflowing it.
// ---------------------------------------------------------------------------
module tb_top;
    import scsde_pkg::*;

    localparam int STACK_SLOTS = 32;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        item_kind_t           item_kind;
        logic [KIND_W-1:0]    kind_out;
        logic [ADDR_BITS-1:0] pointer_out;
        logic [DEPTH_W-1:0]   depth_out;
        logic [DEPTH_W-1:0]   popped_to;
        logic [ADDR_BITS-1:0] frame_address;
        logic                 last;
    } trace_item_t;

    class stack_diff_board;
        logic [ADDR_BITS-1:0] frames [STACK_SLOTS];
        int                   depth;
        int                   mark;
        bit                   failed;
        trace_item_t          expected_items[$];
        int                   failures;

        function trace_item_t make_item(item_kind_t ik, logic [KIND_W-1:0] code,
                                        logic [ADDR_BITS-1:0] ptr, int dep, int mk,
                                        logic [ADDR_BITS-1:0] frame, logic lst);
            trace_item_t it;
            it.item_kind     = ik;
            it.kind_out      = code;
            it.pointer_out   = ptr;
            it.depth_out     = DEPTH_W'(dep);
            it.popped_to     = DEPTH_W'(mk);
            it.frame_address = frame;
            it.last          = lst;
            return it;
        endfunction

        function string describe(trace_item_t it);
            return $sformatf("kind=%0d code=%h ptr=%h depth=%0d mark=%0d frame=%h last=%0d",
                             it.item_kind, it.kind_out, it.pointer_out, it.depth_out,
                             it.popped_to, it.frame_address, it.last);
        endfunction

        function void take_request(req_type_t rq, logic [ADDR_BITS-1:0] caller,
                                   logic [KIND_W-1:0] code, logic [ADDR_BITS-1:0] ptr);
            if (failed)
                return;
            case (rq)
                REQ_PUSH:
                begin
                    if (depth >= STACK_SLOTS)
                        failed = 1'b1;
                    else
                    begin
                        frames[depth] = caller;
                        depth++;
                    end
                end
                REQ_POP:
                begin
                    if (depth > 0)
                    begin
                        depth--;
                        if (mark > depth)
                            mark = depth;
                    end
                end
                REQ_EVENT_STACK:
                begin
                    expected_items.push_back(make_item(ITEM_HEADER, code, ptr, depth, mark,
                                                       '0, mark >= depth));
                    for (int i = mark; i < depth; i++)
                        expected_items.push_back(make_item(ITEM_FRAME, '0, '0, 0, 0,
                                                           frames[i], i + 1 == depth));
                    mark = depth;
                end
                default:
                    expected_items.push_back(make_item(ITEM_HEADER, code, ptr, 0, 0, '0, 1'b1));
            endcase
        endfunction

        function void check_item(trace_item_t got);
            trace_item_t want;
            if (expected_items.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected item: %s", describe(got));
                return;
            end
            want = expected_items.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch exp: %s", describe(want));
                    $display("mismatch got: %s", describe(got));
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           req_type = '0;
    logic [ADDR_BITS-1:0] caller_address = '0;
    logic [KIND_W-1:0]    event_kind = '0;
    logic [ADDR_BITS-1:0] event_pointer = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 item_kind;
    logic [KIND_W-1:0]    kind_out;
    logic [ADDR_BITS-1:0] pointer_out;
    logic [DEPTH_W-1:0]   depth_out;
    logic [DEPTH_W-1:0]   popped_to;
    logic [ADDR_BITS-1:0] frame_address;
    logic                 last;

    stack_diff_board sb = new;
    int              cycle_count = 0;
    int              burst_left = 0;

    shadow_call_stack_diff_emitter #(
        .STACK_DEPTH(STACK_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .caller_address(caller_address),
        .event_kind(event_kind),
        .event_pointer(event_pointer),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .item_kind(item_kind),
        .kind_out(kind_out),
        .pointer_out(pointer_out),
        .depth_out(depth_out),
        .popped_to(popped_to),
        .frame_address(frame_address),
        .last(last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // outputs only change at the rising edge, so the negedge sees what the next edge takes
    always @(negedge clk)
    begin
        trace_item_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_request(req_type_t'(req_type), caller_address, event_kind,
                                event_pointer);
            if (out_valid && out_ready)
            begin
                got.item_kind     = item_kind_t'(item_kind);
                got.kind_out      = kind_out;
                got.pointer_out   = pointer_out;
                got.depth_out     = depth_out;
                got.popped_to     = popped_to;
                got.frame_address = frame_address;
                got.last          = last;
                sb.check_item(got);
            end
        end
    end

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // called right after a rising edge; returns at the edge that takes the item, or later after an idle gap
    task automatic put(req_type_t rq, logic [ADDR_BITS-1:0] caller,
                       logic [KIND_W-1:0] code, logic [ADDR_BITS-1:0] ptr);
        int gap;
        in_valid       <= 1'b1;
        req_type       <= rq;
        caller_address <= caller;
        event_kind     <= code;
        event_pointer  <= ptr;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic put_random(req_type_t rq);
        put(rq, rand_addr(), KIND_W'($urandom_range(0, 255)), rand_addr());
    endtask

    initial
    begin : receiver
        int          mode;
        int          len;
        int unsigned rx_count;
        bit          held_first;
        bit          held_second;
        rx_count = 0;
        held_first = 0;
        held_second = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ((!held_first && rx_count >= 400) || (!held_second && rx_count >= 1000))
            begin
                if (!held_first)
                    held_first = 1;
                else
                    held_second = 1;
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (299) @(posedge clk);
                rx_count += 300;
            end
            mode = $urandom_range(0, 3);
            len = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= 1'b0;
                    default: out_ready <= ~out_ready;
                endcase
                rx_count++;
            end
        end
    end

    initial
    begin : stimulus
        int        pick;
        req_type_t rq;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        burst_left = $urandom_range(1, 24);

        // directed corners
        put(REQ_EVENT_BARE, '0, 8'hFF, '1);
        put(REQ_EVENT_BARE, '1, 8'h00, '0);
        put(REQ_EVENT_STACK, '1, 8'hA5, rand_addr());
        put_random(REQ_POP);
        put(REQ_PUSH, '1, 8'h00, '0);
        put(REQ_PUSH, '0, 8'hFF, '1);
        put_random(REQ_PUSH);
        put(REQ_EVENT_STACK, '0, 8'h00, '1);
        put_random(REQ_EVENT_STACK);
        put_random(REQ_POP);
        put_random(REQ_POP);
        put_random(REQ_PUSH);
        put_random(REQ_PUSH);
        put_random(REQ_EVENT_STACK);
        put_random(REQ_EVENT_BARE);
        put_random(REQ_POP);
        put_random(REQ_POP);
        put_random(REQ_POP);
        put_random(REQ_POP);
        put_random(REQ_EVENT_STACK);

        repeat (340)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                rq = (sb.depth < STACK_SLOTS) ? REQ_PUSH : REQ_POP;
            else if (pick < 65)
                rq = REQ_POP;
            else if (pick < 90)
                rq = REQ_EVENT_STACK;
            else
                rq = REQ_EVENT_BARE;
            put_random(rq);
        end

        // empty the stack, fill it, report every frame, then overflow
        while (sb.depth > 0)
            put_random(REQ_POP);
        put_random(REQ_POP);
        repeat (STACK_SLOTS) put_random(REQ_PUSH);
        put_random(REQ_EVENT_STACK);
        put_random(REQ_PUSH);
        repeat (12) put_random(req_type_t'(2'($urandom_range(0, 3))));

        in_valid <= 1'b0;
        while (sb.expected_items.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
